// File: src/mmvp_pkg.sv
// shared constants and payload types of the mean/variance pair merge
// no dependencies; used by the channel interfaces, the pipeline and the top level
package mmvp_pkg;

   // fixed point layout
   localparam int FRAC_BITS  = 16;
   localparam int CNT_W      = 32;
   localparam int MEAN_W     = 32;
   localparam int VAR_W      = 48;
   localparam int TOT_W      = CNT_W + 1;
   // quotient bits of the mean and between-group divisions
   localparam int MEAN_STEPS = MEAN_W;
   localparam int BQ_W       = 96 - FRAC_BITS;
   // pooled sum of squares widths
   localparam int SV_W       = CNT_W + VAR_W + 1;
   localparam int SS_W       = ((BQ_W > SV_W) ? BQ_W : SV_W) + 1;
   localparam logic [VAR_W-1:0] VAR_MAX = '1;
   localparam logic [CNT_W-1:0] CNT_MAX = '1;

   typedef struct packed {
      logic        [CNT_W-1:0]  old_count;
      logic signed [MEAN_W-1:0] prior_mean;
      logic        [VAR_W-1:0]  old_variance;
      logic        [CNT_W-1:0]  add_count;
      logic signed [MEAN_W-1:0] add_mean;
      logic        [VAR_W-1:0]  add_variance;
      logic                     last_pair;
   } req_type;

   typedef struct packed {
      logic signed [MEAN_W-1:0] merged_mean;
      logic        [VAR_W-1:0]  merged_variance;
      logic        [CNT_W-1:0]  merged_count;
      logic                     empty_flag;
      logic                     saturated_flag;
      logic                     last_out;
   } rsp_type;

endpackage

// File: src/mmvp_if.sv
// valid/ready channel interfaces for merge requests and merge results
// depends on mmvp_pkg for the payload types
interface mmvp_req_if;
   logic             valid;
   logic             ready;
   mmvp_pkg::req_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface mmvp_rsp_if;
   logic             valid;
   logic             ready;
   mmvp_pkg::rsp_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

// File: src/mmvp_pipe.sv
// arithmetic pipeline of the pair merge: products, restoring dividers, final select
// depends on mmvp_pkg; advanced as a whole by the adv enable from the top level
module mmvp_pipe (
   input  logic              clock,
   input  logic              reset,
   input  logic              adv,
   input  logic              in_valid,
   input  mmvp_pkg::req_type in_data,
   output logic              out_valid,
   output mmvp_pkg::rsp_type out_data
);
   import mmvp_pkg::*;

   typedef struct packed {
      logic             last;
      logic [TOT_W-1:0] total;
      logic             an_gt1;
      logic             on_gt1;
      logic [VAR_W-1:0] ov;
      logic [VAR_W-1:0] av;
   } side_type;

   typedef struct packed {
      side_type          side;
      logic [SV_W-1:0]   sv;
      logic              rneg;
      logic [TOT_W-1:0]  m_rem;
      logic [MEAN_W-1:0] m_quo;
      logic [TOT_W-1:0]  b_rem;
      logic [BQ_W-1:0]   b_quo;
   } diva_type;

   typedef struct packed {
      side_type          side;
      logic [TOT_W-1:0]  dvs;
      logic [MEAN_W-1:0] mean;
      logic              satv;
      logic [TOT_W-1:0]  rem;
      logic [VAR_W-1:0]  quo;
   } divb_type;

   // stage 1: magnitudes, total, mean difference
   logic                 s1_valid_ff;
   side_type             s1_side_ff, s1_side_in;
   logic [MEAN_W-1:0]    s1_omag_ff, s1_omag_in, s1_amag_ff, s1_amag_in;
   logic                 s1_oneg_ff, s1_aneg_ff;
   logic [MEAN_W-1:0]    s1_dmag_ff, s1_dmag_in;
   logic [CNT_W-1:0]     s1_on_ff, s1_an_ff, s1_on1_ff, s1_an1_ff;
   logic signed [MEAN_W:0] d_diff;
   logic [MEAN_W:0]      d_mag;

   always_comb begin
      s1_side_in.last   = in_data.last_pair;
      s1_side_in.total  = {1'b0, in_data.old_count} + {1'b0, in_data.add_count};
      s1_side_in.an_gt1 = in_data.add_count > CNT_W'(1);
      s1_side_in.on_gt1 = in_data.old_count > CNT_W'(1);
      s1_side_in.ov     = in_data.old_variance;
      s1_side_in.av     = in_data.add_variance;
      s1_omag_in = in_data.prior_mean[MEAN_W-1] ? (~in_data.prior_mean + MEAN_W'(1))
                                                : in_data.prior_mean;
      s1_amag_in = in_data.add_mean[MEAN_W-1] ? (~in_data.add_mean + MEAN_W'(1))
                                              : in_data.add_mean;
      d_diff = {in_data.add_mean[MEAN_W-1], in_data.add_mean}
             - {in_data.prior_mean[MEAN_W-1], in_data.prior_mean};
      d_mag = d_diff[MEAN_W] ? (~d_diff + (MEAN_W+1)'(1)) : d_diff;
      s1_dmag_in = d_mag[MEAN_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_side_ff <= s1_side_in;
         s1_omag_ff <= s1_omag_in;
         s1_amag_ff <= s1_amag_in;
         s1_oneg_ff <= in_data.prior_mean[MEAN_W-1];
         s1_aneg_ff <= in_data.add_mean[MEAN_W-1];
         s1_dmag_ff <= s1_dmag_in;
         s1_on_ff   <= in_data.old_count;
         s1_an_ff   <= in_data.add_count;
         s1_on1_ff  <= in_data.old_count - CNT_W'(1);
         s1_an1_ff  <= in_data.add_count - CNT_W'(1);
      end
   end

   // stage 2: first level of products
   logic                s2_valid_ff;
   side_type            s2_side_ff;
   logic                s2_oneg_ff, s2_aneg_ff;
   logic [63:0]         s2_m1_ff, s2_m2_ff, s2_dd_ff, s2_ao_ff;
   logic [CNT_W+23:0]   s2_pa_lo_ff, s2_pa_hi_ff, s2_pb_lo_ff, s2_pb_hi_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         s2_side_ff  <= s1_side_ff;
         s2_oneg_ff  <= s1_oneg_ff;
         s2_aneg_ff  <= s1_aneg_ff;
         s2_m1_ff    <= 64'(s1_omag_ff) * 64'(s1_on_ff);
         s2_m2_ff    <= 64'(s1_amag_ff) * 64'(s1_an_ff);
         s2_dd_ff    <= 64'(s1_dmag_ff) * 64'(s1_dmag_ff);
         s2_ao_ff    <= 64'(s1_an_ff) * 64'(s1_on_ff);
         s2_pa_lo_ff <= (CNT_W+24)'(s1_an1_ff) * (CNT_W+24)'(s1_side_ff.av[23:0]);
         s2_pa_hi_ff <= (CNT_W+24)'(s1_an1_ff) * (CNT_W+24)'(s1_side_ff.av[47:24]);
         s2_pb_lo_ff <= (CNT_W+24)'(s1_on1_ff) * (CNT_W+24)'(s1_side_ff.ov[23:0]);
         s2_pb_hi_ff <= (CNT_W+24)'(s1_on1_ff) * (CNT_W+24)'(s1_side_ff.ov[47:24]);
      end
   end

   // stage 3: signed mean sums, partial products of the between-group term
   logic              s3_valid_ff;
   side_type          s3_side_ff;
   logic [63:0]       s3_pos_ff, s3_neg_ff;
   logic [63:0]       s3_p00_ff, s3_p01_ff, s3_p10_ff, s3_p11_ff;
   logic [SV_W-2:0]   s3_pa_ff, s3_pb_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         s3_side_ff <= s2_side_ff;
         s3_pos_ff  <= (s2_oneg_ff ? 64'd0 : s2_m1_ff) + (s2_aneg_ff ? 64'd0 : s2_m2_ff);
         s3_neg_ff  <= (s2_oneg_ff ? s2_m1_ff : 64'd0) + (s2_aneg_ff ? s2_m2_ff : 64'd0);
         s3_p00_ff  <= 64'(s2_ao_ff[31:0]) * 64'(s2_dd_ff[31:0]);
         s3_p01_ff  <= 64'(s2_ao_ff[31:0]) * 64'(s2_dd_ff[63:32]);
         s3_p10_ff  <= 64'(s2_ao_ff[63:32]) * 64'(s2_dd_ff[31:0]);
         s3_p11_ff  <= 64'(s2_ao_ff[63:32]) * 64'(s2_dd_ff[63:32]);
         s3_pa_ff   <= (SV_W-1)'(s2_pa_lo_ff) + {s2_pa_hi_ff, 24'd0};
         s3_pb_ff   <= (SV_W-1)'(s2_pb_lo_ff) + {s2_pb_hi_ff, 24'd0};
      end
   end

   // stage 4: mean magnitude, full between-group product, pooled sum
   logic              s4_valid_ff;
   side_type          s4_side_ff;
   logic              s4_rneg_ff;
   logic [63:0]       s4_m_ff;
   logic [127:0]      s4_x_ff;
   logic [SV_W-1:0]   s4_sv_ff;
   logic              rneg_in;

   assign rneg_in = s3_neg_ff > s3_pos_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         s4_side_ff <= s3_side_ff;
         s4_rneg_ff <= rneg_in;
         s4_m_ff    <= rneg_in ? (s3_neg_ff - s3_pos_ff) : (s3_pos_ff - s3_neg_ff);
         s4_x_ff    <= 128'(s3_p00_ff) + {32'd0, s3_p01_ff, 32'd0}
                     + {32'd0, s3_p10_ff, 32'd0} + {s3_p11_ff, 64'd0};
         s4_sv_ff   <= SV_W'(s3_pa_ff) + SV_W'(s3_pb_ff);
      end
   end

   // divider A: between-group quotient, mean quotient in the first steps
   diva_type a0;
   diva_type a_in [BQ_W];
   diva_type a_ff [BQ_W];
   logic     a_valid_ff [BQ_W];

   always_comb begin
      a0.side  = s4_side_ff;
      a0.sv    = s4_sv_ff;
      a0.rneg  = s4_rneg_ff;
      a0.m_rem = {1'b0, s4_m_ff[63:32]};
      a0.m_quo = s4_m_ff[31:0];
      a0.b_rem = {1'b0, s4_x_ff[127:96]};
      a0.b_quo = s4_x_ff[95:FRAC_BITS];
   end

   genvar k;
   for (k = 0; k < BQ_W; k++) begin : g_diva
      diva_type        src;
      logic            src_valid;
      logic [TOT_W:0]  bt, bd, mt, md;

      if (k == 0) begin : g_first
         assign src       = a0;
         assign src_valid = s4_valid_ff;
      end else begin : g_next
         assign src       = a_ff[k-1];
         assign src_valid = a_valid_ff[k-1];
      end

      // one restoring step per stage
      always_comb begin
         a_in[k] = src;
         bt = {src.b_rem, src.b_quo[BQ_W-1]};
         bd = bt - {1'b0, src.side.total};
         a_in[k].b_rem = bd[TOT_W] ? bt[TOT_W-1:0] : bd[TOT_W-1:0];
         a_in[k].b_quo = {src.b_quo[BQ_W-2:0], ~bd[TOT_W]};
         mt = {src.m_rem, src.m_quo[MEAN_W-1]};
         md = mt - {1'b0, src.side.total};
         if (k < MEAN_STEPS) begin
            a_in[k].m_rem = md[TOT_W] ? mt[TOT_W-1:0] : md[TOT_W-1:0];
            a_in[k].m_quo = {src.m_quo[MEAN_W-2:0], ~md[TOT_W]};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            a_valid_ff[k] <= 1'b0;
         end else if (adv) begin
            a_valid_ff[k] <= src_valid;
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            a_ff[k] <= a_in[k];
         end
      end
   end

   // stage B1: pooled sum of squares, divisor, rounded mean
   diva_type          a_last;
   logic              b1_valid_ff;
   side_type          b1_side_ff;
   logic [SS_W-1:0]   b1_ss_ff;
   logic [TOT_W-1:0]  b1_dvs_ff;
   logic [MEAN_W-1:0] b1_mean_ff, mean_q, mean_in;
   logic              round_up;

   assign a_last = a_ff[BQ_W-1];

   always_comb begin
      round_up = {a_last.m_rem, 1'b0} >= {1'b0, a_last.side.total};
      mean_q   = a_last.m_quo + MEAN_W'(round_up);
      if (a_last.side.total == '0) begin
         mean_in = '0;
      end else if (a_last.rneg) begin
         mean_in = ~mean_q + MEAN_W'(1);
      end else begin
         mean_in = mean_q;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         b1_side_ff <= a_last.side;
         b1_ss_ff   <= SS_W'(a_last.sv) + SS_W'(a_last.b_quo);
         b1_dvs_ff  <= a_last.side.total - TOT_W'(1);
         b1_mean_ff <= mean_in;
      end
   end

   // stage B2: overflow check against the divisor and divider set-up
   divb_type  b0_in, b0_ff;
   logic      b0_valid_ff;

   always_comb begin
      b0_in.side = b1_side_ff;
      b0_in.dvs  = b1_dvs_ff;
      b0_in.mean = b1_mean_ff;
      b0_in.satv = b1_ss_ff[SS_W-1:VAR_W] >= (SS_W-VAR_W)'(b1_dvs_ff);
      b0_in.rem  = b1_ss_ff[VAR_W+TOT_W-1:VAR_W];
      b0_in.quo  = b1_ss_ff[VAR_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         b0_ff <= b0_in;
      end
   end

   // divider B: pooled sum over count minus one
   divb_type b_in [VAR_W];
   divb_type b_ff [VAR_W];
   logic     b_valid_ff [VAR_W];

   for (k = 0; k < VAR_W; k++) begin : g_divb
      divb_type        src;
      logic            src_valid;
      logic [TOT_W:0]  vt, vd;

      if (k == 0) begin : g_first
         assign src       = b0_ff;
         assign src_valid = b0_valid_ff;
      end else begin : g_next
         assign src       = b_ff[k-1];
         assign src_valid = b_valid_ff[k-1];
      end

      always_comb begin
         b_in[k] = src;
         vt = {src.rem, src.quo[VAR_W-1]};
         vd = vt - {1'b0, src.dvs};
         b_in[k].rem = vd[TOT_W] ? vt[TOT_W-1:0] : vd[TOT_W-1:0];
         b_in[k].quo = {src.quo[VAR_W-2:0], ~vd[TOT_W]};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            b_valid_ff[k] <= 1'b0;
         end else if (adv) begin
            b_valid_ff[k] <= src_valid;
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            b_ff[k] <= b_in[k];
         end
      end
   end

   // output register: variance choice, count clipping, flags
   divb_type b_last;
   rsp_type  out_in, out_ff;
   logic     out_valid_ff;
   logic     both_gt1;

   assign b_last = b_ff[VAR_W-1];

   always_comb begin
      both_gt1 = b_last.side.an_gt1 & b_last.side.on_gt1;
      out_in.merged_mean = b_last.mean;
      if (both_gt1) begin
         out_in.merged_variance = b_last.satv ? VAR_MAX : b_last.quo;
      end else if (b_last.side.an_gt1) begin
         out_in.merged_variance = b_last.side.av;
      end else begin
         out_in.merged_variance = b_last.side.ov;
      end
      out_in.merged_count   = b_last.side.total[CNT_W] ? CNT_MAX
                                                       : b_last.side.total[CNT_W-1:0];
      out_in.empty_flag     = b_last.side.total == '0;
      out_in.saturated_flag = b_last.side.total[CNT_W] | (both_gt1 & b_last.satv);
      out_in.last_out       = b_last.side.last;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         out_ff <= out_in;
      end
   end

   // valid bits of the fixed stages
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         s4_valid_ff  <= 1'b0;
         b1_valid_ff  <= 1'b0;
         b0_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_valid_ff  <= in_valid;
         s2_valid_ff  <= s1_valid_ff;
         s3_valid_ff  <= s2_valid_ff;
         s4_valid_ff  <= s3_valid_ff;
         b1_valid_ff  <= a_valid_ff[BQ_W-1];
         b0_valid_ff  <= b1_valid_ff;
         out_valid_ff <= b_valid_ff[VAR_W-1];
      end
   end

   assign out_valid = out_valid_ff;
   assign out_data  = out_ff;

endmodule

// File: src/merge_mean_variance_pair_unit.sv
// Merge of two (count, mean, sample variance) summaries into one.
// Requests arrive on req_if and results leave on rsp_if, both valid/ready
// channels; a transfer happens on a clock edge with valid and ready high.
// Each request gives exactly one result, in request order.
// Means are signed Q16.16, variances unsigned Q32.16; count and variance
// saturate and raise saturated_flag, two empty groups give mean 0 and
// empty_flag.
// The depth is set by the restoring dividers, one quotient bit per stage, for
// the between-group term and then for the pooled sum of squares. One request
// is taken every cycle while the output register is not stalled.
// Reset (synchronous, active high) empties every stage; the block takes
// requests in the cycle after reset falls.
// The last stage is the output register. While it holds a result that the
// receiver does not take, the whole pipeline holds and req_if.ready is low;
// nothing is dropped or repeated.
// depends on mmvp_pkg, mmvp_if and mmvp_pipe
module merge_mean_variance_pair_unit (
   input logic       clock,
   input logic       reset,
   mmvp_req_if.sink   req_if,
   mmvp_rsp_if.source rsp_if
);
   import mmvp_pkg::*;

   logic adv;

   // the pipeline moves when the output register is empty or being drained
   assign adv          = ~rsp_if.valid | rsp_if.ready;
   assign req_if.ready = adv & ~reset;

   mmvp_pipe u_pipe (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (req_if.valid),
      .in_data   (req_if.data),
      .out_valid (rsp_if.valid),
      .out_data  (rsp_if.data)
   );

   // empty groups give a zero mean and count, never a clip
   a_empty : assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid && rsp_if.data.empty_flag |->
         rsp_if.data.merged_mean == '0 && rsp_if.data.merged_count == '0
         && !rsp_if.data.saturated_flag)
      else $error("empty result with non-zero fields");

   // a clip shows as a full-scale count or variance
   a_sat : assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid && rsp_if.data.saturated_flag |->
         rsp_if.data.merged_count == CNT_MAX || rsp_if.data.merged_variance == VAR_MAX)
      else $error("saturated flag without a clipped field");

   // a stalled result blocks new request transfers
   a_stall : assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid && !rsp_if.ready |-> !req_if.ready)
      else $error("request taken while the output is stalled");

   // a held result is released only by a transfer
   a_hold : assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid && !rsp_if.ready |=> rsp_if.valid && $stable(rsp_if.data))
      else $error("stalled result changed");

endmodule

// File: test/tb_merge_mean_variance_pair_unit.sv
// self-checking testbench for merge_mean_variance_pair_unit: directed and random merges
// depends on mmvp_pkg, mmvp_if and the unit; predicts each result with wide arithmetic, up to 128 bits
`timescale 1ns / 100ps

module tb_merge_mean_variance_pair_unit;
   import mmvp_pkg::*;

   localparam int LATENCY = 55 + 96 - FRAC_BITS;

   logic clock = 1'b0;
   logic reset = 1'b1;
   mmvp_req_if req_if ();
   mmvp_rsp_if rsp_if ();

   merge_mean_variance_pair_unit dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if)
   );

   always #2 clock = ~clock;

   req_type pending_merges[$];
   rsp_type expected_merges[$];
   int      mismatch_count = 0;
   int      send_idle_pct = 0;
   int      recv_stall_pct = 0;
   bit      hold_off_req = 1'b0;
   bit      hold_off_done = 1'b0;
   int      hold_off_count = 0;

   // merge prediction, exact in wide arithmetic
   function automatic rsp_type merge_pair(req_type r);
      rsp_type           m;
      logic [32:0]       total;
      logic signed [65:0] wsum;
      logic [63:0]       mag, q, rem;
      logic signed [32:0] diff;
      logic [127:0]      dm, between, pooled, quot;
      logic [32:0]       on, an;
      on = {1'b0, r.old_count};
      an = {1'b0, r.add_count};
      total = on + an;
      m = '0;
      m.last_out = r.last_pair;
      m.merged_variance = r.old_variance;
      if (total == 0) begin
         m.empty_flag = 1'b1;
      end else begin
         wsum = $signed(r.prior_mean) * $signed({1'b0, on})
              + $signed(r.add_mean) * $signed({1'b0, an});
         mag = (wsum < 0) ? 64'(-wsum) : 64'(wsum);
         q = mag / 64'(total);
         rem = mag % 64'(total);
         if (rem >= 64'(total) - rem) q = q + 1;
         m.merged_mean = (wsum < 0) ? 32'(-q) : 32'(q);
      end
      if (total > 1) begin
         if (an > 1 && on > 1) begin
            diff = $signed({r.add_mean[31], r.add_mean})
                 - $signed({r.prior_mean[31], r.prior_mean});
            dm = (diff < 0) ? 128'(-diff) : 128'(diff);
            between = ((128'(an) * 128'(on) * dm * dm) >> FRAC_BITS) / 128'(total);
            pooled = 128'(an - 1) * 128'(r.add_variance)
                   + 128'(on - 1) * 128'(r.old_variance) + between;
            quot = pooled / 128'(total - 1);
            if (quot > 128'(VAR_MAX)) begin
               m.merged_variance = VAR_MAX;
               m.saturated_flag = 1'b1;
            end else begin
               m.merged_variance = quot[VAR_W-1:0];
            end
         end else if (an > 1) begin
            m.merged_variance = r.add_variance;
         end else if (on > 1) begin
            m.merged_variance = r.old_variance;
         end
      end
      if (total > 33'(CNT_MAX)) begin
         m.merged_count = CNT_MAX;
         m.saturated_flag = 1'b1;
      end else begin
         m.merged_count = total[CNT_W-1:0];
      end
      return m;
   endfunction

   task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      $display("error: %s got %h expected %h at %0t", what, got, want, $realtime);
      mismatch_count++;
   endtask

   // driver: offers the head of the queue, holds it until the transfer
   always @(posedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
         req_if.data <= '0;
      end else if (!req_if.valid || req_if.ready) begin
         if (req_if.valid && req_if.ready) begin
            expected_merges.push_back(merge_pair(req_if.data));
            void'(pending_merges.pop_front());
         end
         if (pending_merges.size() > 0) begin
            if ($urandom_range(99) >= send_idle_pct) begin
               req_if.valid <= 1'b1;
               req_if.data <= pending_merges[0];
            end else begin
               req_if.valid <= 1'b0;
            end
         end else begin
            req_if.valid <= 1'b0;
         end
      end
   end

   // receiver hold-off: counts its own stretch of cycles once requested
   always @(posedge clock) begin
      if (hold_off_req && !hold_off_done) begin
         if (hold_off_count == 3 * LATENCY - 1) begin
            hold_off_done <= 1'b1;
         end else begin
            hold_off_count <= hold_off_count + 1;
         end
      end
   end

   // monitor: compares each result transfer against the oldest prediction
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            if (expected_merges.size() == 0) begin
               report_mismatch("unexpected result", 64'(rsp_if.data), '0);
            end else begin
               want = expected_merges.pop_front();
               if (rsp_if.data.merged_mean !== want.merged_mean)
                  report_mismatch("merged_mean", 64'(rsp_if.data.merged_mean),
                                  64'(want.merged_mean));
               if (rsp_if.data.merged_variance !== want.merged_variance)
                  report_mismatch("merged_variance", 64'(rsp_if.data.merged_variance),
                                  64'(want.merged_variance));
               if (rsp_if.data.merged_count !== want.merged_count)
                  report_mismatch("merged_count", 64'(rsp_if.data.merged_count),
                                  64'(want.merged_count));
               if (rsp_if.data.empty_flag !== want.empty_flag)
                  report_mismatch("empty_flag", 64'(rsp_if.data.empty_flag),
                                  64'(want.empty_flag));
               if (rsp_if.data.saturated_flag !== want.saturated_flag)
                  report_mismatch("saturated_flag", 64'(rsp_if.data.saturated_flag),
                                  64'(want.saturated_flag));
               if (rsp_if.data.last_out !== want.last_out)
                  report_mismatch("last_out", 64'(rsp_if.data.last_out),
                                  64'(want.last_out));
            end
         end
         if (hold_off_req && !hold_off_done) begin
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= ($urandom_range(99) >= recv_stall_pct);
         end
      end
   end

   function automatic logic [31:0] pick_count();
      case ($urandom_range(7))
         0: return $urandom_range(2);
         1: return 32'hFFFF_FFFF - $urandom_range(3);
         2: return $urandom;
         3: return 32'h8000_0000 + $urandom_range(7);
         default: return $urandom_range(1000);
      endcase
   endfunction

   function automatic logic [47:0] pick_variance();
      case ($urandom_range(3))
         0: return 48'({$urandom, $urandom});
         1: return VAR_MAX - $urandom_range(3);
         default: return 48'($urandom_range(1 << 24));
      endcase
   endfunction

   function automatic req_type random_merge();
      req_type r;
      r.old_count = pick_count();
      r.add_count = pick_count();
      r.prior_mean = $urandom;
      r.add_mean = ($urandom_range(3) == 0) ? r.prior_mean : 32'($urandom);
      r.old_variance = pick_variance();
      r.add_variance = pick_variance();
      r.last_pair = 1'($urandom_range(1));
      return r;
   endfunction

   function automatic req_type make_merge(logic [31:0] oc, logic [31:0] om, logic [47:0] ov,
                                          logic [31:0] ac, logic [31:0] am, logic [47:0] av,
                                          logic lp);
      req_type r;
      r.old_count = oc; r.prior_mean = om; r.old_variance = ov;
      r.add_count = ac; r.add_mean = am; r.add_variance = av;
      r.last_pair = lp;
      return r;
   endfunction

   task automatic run_phase(int items, int idle_pct, int stall_pct);
      send_idle_pct = idle_pct;
      recv_stall_pct = stall_pct;
      repeat (items) pending_merges.push_back(random_merge());
      wait (pending_merges.size() == 0);
   endtask

   // stimulus
   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      // directed: empty groups, single reads, extremes, overflow cases
      pending_merges.push_back(make_merge(0, 32'h1234, 48'h55, 0, 32'h8000_0000, 48'h1, 1'b1));
      pending_merges.push_back(make_merge(1, 32'h0001_0000, 48'h77, 1, 32'hFFFF_0000, 48'h9,
                                          1'b0));
      pending_merges.push_back(make_merge(0, 0, 48'h3, 5, 32'h7FFF_FFFF, VAR_MAX, 1'b1));
      pending_merges.push_back(make_merge(7, 32'h8000_0000, VAR_MAX, 1, 0, 0, 1'b0));
      pending_merges.push_back(make_merge(2, 32'h7FFF_FFFF, 0, 2, 32'h8000_0000, 0, 1'b1));
      pending_merges.push_back(make_merge(CNT_MAX, 32'h7FFF_FFFF, VAR_MAX,
                                          CNT_MAX, 32'h8000_0000, VAR_MAX, 1'b0));
      pending_merges.push_back(make_merge(3, 32'h0000_8000, 48'h1_0000, 1, 32'h0, 0, 1'b1));
      pending_merges.push_back(make_merge(1, 32'h0, 0, 2, 32'hFFFF_FFFF, 48'h10, 1'b0));
      pending_merges.push_back(make_merge(CNT_MAX, 0, 48'h100, 1, 32'h10, 48'h5, 1'b1));
      pending_merges.push_back(make_merge(100, 32'hFFFF_8000, 48'hABCD, 300, 32'h0003_0000,
                                          48'h12_3456, 1'b0));
      pending_merges.push_back(make_merge(1, 32'h0000_0001, 0, 2, 32'hFFFF_FFFF, 0, 1'b1));
      wait (pending_merges.size() == 0);
      run_phase(400, 0, 0);
      run_phase(350, 68, 0);
      run_phase(350, 0, 68);
      run_phase(300, 7, 7);
      // long receiver hold-off so the pipeline fills and stalls the input
      send_idle_pct = 0;
      recv_stall_pct = 0;
      hold_off_req = 1'b1;
      repeat (250) pending_merges.push_back(random_merge());
      wait (pending_merges.size() == 0);
      // sender pause until the pipeline drains
      wait (expected_merges.size() == 0);
      run_phase(50, 0, 0);
      wait (expected_merges.size() == 0);
      repeat (LATENCY + 10) @(posedge clock);
      if (mismatch_count == 0 && expected_merges.size() == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // timeout
   initial begin
      #4_000_000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

// File: files.f
src/mmvp_pkg.sv
src/mmvp_if.sv
src/mmvp_pipe.sv
src/merge_mean_variance_pair_unit.sv
test/tb_merge_mean_variance_pair_unit.sv
